@@ sv/cavp_pkg.sv @@
// cavp_pkg: shared types and constants for the cave automaton row pass
// used by the interfaces, the cell, the result queue and the top level
package cavp_pkg;

  localparam int DATA_W       = 64;
  localparam int ROW_CELLS_DEF = 64;
  localparam int WIDTH_W      = 7;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd64;

  localparam logic [3:0] LIVE_STAY  = 4'd5;
  localparam logic [3:0] DEAD_BIRTH = 4'd6;

  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  // masked column bits of the three rows that a cell shows its neighbours
  typedef struct packed {
    logic up;
    logic mid;
    logic down;
  } cavp_nb_t;

  // per-cycle control shared by every cell
  typedef struct packed {
    logic load;
    logic held;
  } cavp_ctrl_t;

  typedef struct packed {
    logic [DATA_W-1:0] next_cells;
    logic              frame_end;
  } cavp_res_t;

endpackage

@@ sv/cavp_ifs.sv @@
// cavp_ifs: valid/ready channels for input rows and result rows
// depends on cavp_pkg
interface cavp_row_if
  import cavp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] row_cells;
  logic              final_row;

  modport source (output valid, output row_cells, output final_row, input ready);
  modport sink (input valid, input row_cells, input final_row, output ready);
endinterface

interface cavp_res_if
  import cavp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] next_cells;
  logic              frame_end;

  modport source (output valid, output next_cells, output frame_end, input ready);
  modport sink (input valid, input next_cells, input frame_end, output ready);
endinterface

@@ sv/cavp_cell.sv @@
// cavp_cell: one grid column, holds its bits of the two earlier rows
// and evaluates both neighbour counts; depends on cavp_pkg
module cavp_cell
  import cavp_pkg::*;
(
  input  logic       clk,
  input  logic       col_ok,
  input  logic       in_bit,
  input  cavp_ctrl_t ctrl,
  input  cavp_nb_t   left,
  input  cavp_nb_t   right,
  output cavp_nb_t   own,
  output logic       res_a,
  output logic       res_b
);

  logic older;
  logic newer;
  logic [3:0] cnt_a;
  logic [3:0] cnt_b;
  logic up_l;
  logic up_c;
  logic up_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      older <= ctrl.held ? newer : 1'b1;
      newer <= in_bit;
    end
  end

  // outside the set width a column reads as wall
  assign own.up   = col_ok ? older : 1'b1;
  assign own.mid  = col_ok ? newer : 1'b1;
  assign own.down = col_ok ? in_bit : 1'b1;

  // row above for the bottom row result: wall when no row is held
  assign up_l = ctrl.held ? left.mid : 1'b1;
  assign up_c = ctrl.held ? own.mid : 1'b1;
  assign up_r = ctrl.held ? right.mid : 1'b1;

  assign cnt_a = {3'b0, left.up} + {3'b0, own.up} + {3'b0, right.up}
               + {3'b0, left.mid} + {3'b0, right.mid}
               + {3'b0, left.down} + {3'b0, own.down} + {3'b0, right.down};

  assign cnt_b = {3'b0, up_l} + {3'b0, up_c} + {3'b0, up_r}
               + {3'b0, left.down} + {3'b0, right.down} + 4'd3;

  assign res_a = col_ok & (own.mid ? (cnt_a >= LIVE_STAY) : (cnt_a >= DEAD_BIRTH));
  assign res_b = col_ok & (own.down ? (cnt_b >= LIVE_STAY) : (cnt_b >= DEAD_BIRTH));

endmodule

@@ sv/cavp_queue.sv @@
// cavp_queue: small result queue, takes up to two results a cycle
// and drives the result channel from registers; depends on cavp_pkg, cavp_ifs
module cavp_queue
  import cavp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push_a,
  input  logic        push_b,
  input  cavp_res_t   data_a,
  input  cavp_res_t   data_b,
  output logic        room,
  cavp_res_if.source  results
);

  cavp_res_t mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] head;
  logic [QUEUE_AW-1:0] tail;
  logic [QUEUE_AW:0]   fill;
  logic [QUEUE_AW:0]   fill_next;
  logic [QUEUE_AW-1:0] tail_b;
  logic                pop;

  assign pop    = results.valid & results.ready;
  assign tail_b = tail + {{(QUEUE_AW-1){1'b0}}, push_a};
  assign fill_next = fill + {{QUEUE_AW{1'b0}}, push_a} + {{QUEUE_AW{1'b0}}, push_b}
                   - {{QUEUE_AW{1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      fill <= fill_next;
      tail <= tail + {{(QUEUE_AW-1){1'b0}}, push_a} + {{(QUEUE_AW-1){1'b0}}, push_b};
      if (pop) begin
        head <= head + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem[tail] <= data_a;
    end
    if (push_b) begin
      mem[tail_b] <= data_b;
    end
  end

  // two free slots for the worst case of a bottom row
  assign room = fill <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2);

  assign results.valid      = fill != '0;
  assign results.next_cells = mem[head].next_cells;
  assign results.frame_end  = mem[head].frame_end;

endmodule

@@ sv/cave_automaton_row_pass_top.sv @@
// Cave smoothing row pass: one generation of the cave automaton per pass over a grid that
// arrives one row per request, row 0 first, the bottom row flagged by final_row. A row is
// taken in every clock while the result queue has two free slots; each row after the first
// yields the result of the row above it; the bottom row also yields itself with frame_end
// set. The output drains one result a clock while results.ready is high, so a grid of R
// rows takes R requests at the input and gives R results at the output. Neighbours
// outside the grid, and columns at or beyond grid_width, count as wall; result bits at or
// beyond grid_width are zero. grid_width resets to 64; the user must write it only while
// idle (not enforced by the block). Depends on cavp_pkg, cavp_ifs, cavp_cell, cavp_queue.
module cave_automaton_row_pass_top
  import cavp_pkg::*;
#(
  parameter int ROW_CELLS = ROW_CELLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [WIDTH_W-1:0] cfg_wr_data,
  cavp_row_if.sink           rows,
  cavp_res_if.source         results
);

  logic [WIDTH_W-1:0] grid_width;
  logic               held;
  logic               accept;
  logic               room;
  cavp_ctrl_t         ctrl;
  cavp_nb_t           nb [ROW_CELLS+2];
  logic [DATA_W-1:0]  res_a;
  logic [DATA_W-1:0]  res_b;
  logic [DATA_W-1:0]  col_mask;
  cavp_res_t          data_a;
  cavp_res_t          data_b;

  assign rows.ready = room;
  assign accept     = rows.valid & rows.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= WIDTH_RESET;
      held       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        grid_width <= cfg_wr_data;
      end
      if (accept) begin
        held <= ~rows.final_row;
      end
    end
  end

  assign ctrl.load = accept & ~rows.final_row;
  assign ctrl.held = held;

  // columns beyond either edge read as wall
  assign nb[0]           = '1;
  assign nb[ROW_CELLS+1] = '1;

  for (genvar i = 0; i < DATA_W; i++) begin : g_col
    if (i < ROW_CELLS) begin : g_cell
      assign col_mask[i] = WIDTH_W'(i) < grid_width;
      cavp_cell u_cell (
        .clk    (clk),
        .col_ok (col_mask[i]),
        .in_bit (rows.row_cells[i]),
        .ctrl   (ctrl),
        .left   (nb[i]),
        .right  (nb[i+2]),
        .own    (nb[i+1]),
        .res_a  (res_a[i]),
        .res_b  (res_b[i])
      );
    end else begin : g_none
      assign col_mask[i] = 1'b0;
      assign res_a[i]    = 1'b0;
      assign res_b[i]    = 1'b0;
    end
  end

  assign data_a.next_cells = res_a;
  assign data_a.frame_end  = 1'b0;
  assign data_b.next_cells = res_b;
  assign data_b.frame_end  = 1'b1;

  cavp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_a  (accept & held),
    .push_b  (accept & rows.final_row),
    .data_a  (data_a),
    .data_b  (data_b),
    .room    (room),
    .results (results)
  );

`ifndef SYNTHESIS
  a_first_row_held: assert property (@(posedge clk) disable iff (rst)
    accept && !rows.final_row |=> held)
    else $error("row not held after a non-bottom request");

  a_bottom_clears: assert property (@(posedge clk) disable iff (rst)
    accept && rows.final_row |=> !held)
    else $error("grid not closed after the bottom row");

  a_result_masked: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.next_cells & ~col_mask) == '0)
    else $error("result bit set beyond the grid width");

  a_bottom_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && rows.final_row |=> results.valid)
    else $error("no result queued after the bottom row");
`endif

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for cave_automaton_row_pass_top, directed table then random grids
// depends on cavp_pkg, cavp_ifs and the top level; predicts result rows internally, but typed table rows give theirs
module tb
  import cavp_pkg::*;
();

  typedef enum logic [1:0] {
    ACT_ROW,
    ACT_WIDTH
  } plan_act_t;

  typedef struct packed {
    plan_act_t         act;
    logic [DATA_W-1:0] data;
    logic              fin;
    logic              typed;
    logic [DATA_W-1:0] want;
  } plan_row_t;

  localparam int PLAN_LEN = 25;
  localparam logic [DATA_W-1:0] ONES = {DATA_W{1'b1}};

  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{ACT_ROW,   64'h0,                   1'b1, 1'b1, ONES},
    '{ACT_ROW,   ONES,                    1'b1, 1'b1, ONES},
    '{ACT_ROW,   64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 64'h0},
    '{ACT_ROW,   64'h5555_5555_5555_5555, 1'b0, 1'b0, 64'h0},
    '{ACT_ROW,   64'h8000_0000_0000_0001, 1'b0, 1'b0, 64'h0},
    '{ACT_ROW,   64'h0000_FFFF_0000_FFFF, 1'b1, 1'b0, 64'h0},
    '{ACT_WIDTH, 64'd0,                   1'b0, 1'b0, 64'h0},
    '{ACT_ROW,   64'hDEAD_BEEF_0123_4567, 1'b1, 1'b1, 64'h0},
    '{ACT_ROW,   ONES,                    1'b0, 1'b0, 64'h0},
    '{ACT_ROW,   64'h0,                   1'b1, 1'b0, 64'h0},
    '{ACT_WIDTH, 64'd1,                   1'b0, 1'b0, 64'h0},
    '{ACT_ROW,   64'h0,                   1'b1, 1'b1, 64'h1},
    '{ACT_WIDTH, 64'd127,                 1'b0, 1'b0, 64'h0},
    '{ACT_ROW,   64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 64'h0},
    '{ACT_ROW,   64'hF0F0_F0F0_F0F0_F0F0, 1'b1, 1'b0, 64'h0},
    '{ACT_WIDTH, 64'd3,                   1'b0, 1'b0, 64'h0},
    '{ACT_ROW,   64'hFFFF_FFFF_FFFF_FFF8, 1'b0, 1'b0, 64'h0},
    '{ACT_ROW,   64'h2,                   1'b0, 1'b0, 64'h0},
    '{ACT_ROW,   64'h5,                   1'b1, 1'b0, 64'h0},
    '{ACT_WIDTH, 64'd64,                  1'b0, 1'b0, 64'h0},
    '{ACT_ROW,   64'h1,                   1'b0, 1'b0, 64'h0},
    '{ACT_WIDTH, 64'd10,                  1'b0, 1'b0, 64'h0},
    '{ACT_ROW,   64'hFFFF_FFFF_0000_03F0, 1'b0, 1'b0, 64'h0},
    '{ACT_ROW,   64'h0,                   1'b1, 1'b0, 64'h0},
    '{ACT_WIDTH, 64'd64,                  1'b0, 1'b0, 64'h0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en;
  logic [WIDTH_W-1:0] cfg_wr_data;

  cavp_row_if rows_if ();
  cavp_res_if res_if ();

  cave_automaton_row_pass_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .rows       (rows_if),
    .results    (res_if)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [WIDTH_W-1:0] width_reg;
  logic [DATA_W-1:0]  above_row;
  logic [DATA_W-1:0]  held_row;
  logic [1:0]         held_count;

  cavp_res_t pending_rows [$];
  cavp_res_t head_row;
  int        faults;
  int        sent_rows;
  bit        calm;

  function automatic logic [DATA_W-1:0] lane_mask(input logic [WIDTH_W-1:0] w);
    if (w >= ROW_CELLS_DEF) begin
      return ONES;
    end
    return (64'd1 << w) - 64'd1;
  endfunction

  function automatic logic [DATA_W-1:0] smooth_row(input logic [DATA_W-1:0] up,
                                                   input logic [DATA_W-1:0] mid,
                                                   input logic [DATA_W-1:0] down);
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] nxt;
    logic [DATA_W-1:0] lines [3];
    int                cnt;
    logic              lft;
    logic              rgt;
    m = lane_mask(width_reg);
    lines[0] = (up & m) | ~m;
    lines[1] = (mid & m) | ~m;
    lines[2] = (down & m) | ~m;
    nxt = '0;
    for (int c = 0; c < DATA_W; c++) begin
      cnt = 0;
      for (int r = 0; r < 3; r++) begin
        lft = (c == 0) ? 1'b1 : lines[r][(c == 0) ? 0 : c - 1];
        rgt = (c == DATA_W - 1) ? 1'b1 : lines[r][(c == DATA_W - 1) ? c : c + 1];
        cnt = cnt + int'(lft) + int'(rgt);
        if (r != 1) cnt = cnt + int'(lines[r][c]);
      end
      nxt[c] = lines[1][c] ? (cnt >= int'(LIVE_STAY)) : (cnt >= int'(DEAD_BIRTH));
    end
    return nxt & m;
  endfunction

  task automatic advance_grid(input logic [DATA_W-1:0] cells, input logic fin,
                              output cavp_res_t first, output cavp_res_t second,
                              output int n);
    n = 0;
    if (held_count == 2'd0) begin
      if (fin) begin
        first = '{next_cells: smooth_row(ONES, cells, ONES), frame_end: 1'b1};
        n = 1;
      end else begin
        above_row  = ONES;
        held_row   = cells;
        held_count = 2'd1;
      end
    end else begin
      first = '{next_cells: smooth_row(above_row, held_row, cells), frame_end: 1'b0};
      n = 1;
      if (fin) begin
        second = '{next_cells: smooth_row(held_row, cells, ONES), frame_end: 1'b1};
        n = 2;
        above_row  = '0;
        held_row   = '0;
        held_count = 2'd0;
      end else begin
        above_row  = held_row;
        held_row   = cells;
        held_count = 2'd2;
      end
    end
  endtask

  task automatic put_row(input logic [DATA_W-1:0] cells, input logic fin,
                         input logic typed, input logic [DATA_W-1:0] want);
    cavp_res_t first;
    cavp_res_t second;
    int        n;
    while (!calm && $urandom_range(99) < 37) begin
      rows_if.valid <= 1'b0;
      @(negedge clk);
    end
    rows_if.valid     <= 1'b1;
    rows_if.row_cells <= cells;
    rows_if.final_row <= fin;
    do @(posedge clk); while (!rows_if.ready);
    advance_grid(cells, fin, first, second, n);
    if (typed) begin
      pending_rows.push_back('{next_cells: want, frame_end: 1'b1});
    end else begin
      if (n > 0) pending_rows.push_back(first);
      if (n > 1) pending_rows.push_back(second);
    end
    sent_rows++;
    @(negedge clk);
  endtask

  task automatic set_width(input logic [WIDTH_W-1:0] w);
    rows_if.valid <= 1'b0;
    while (pending_rows.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    width_reg = w;
  endtask

  function automatic logic [WIDTH_W-1:0] pick_width();
    case ($urandom_range(9))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd2;
      3:       return 7'd63;
      4:       return 7'd127;
      5, 6:    return 7'd64;
      default: return WIDTH_W'($urandom_range(127));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] make_row();
    case ($urandom_range(7))
      0:       return ONES;
      1:       return '0;
      2:       return {$urandom, $urandom} & {$urandom, $urandom};
      3:       return {$urandom, $urandom} | {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // result side
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_if.ready <= calm || ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_rows.size() == 0) begin
        faults++;
        $display("%0t: unexpected result, expected none, actual next_cells %h frame_end %b",
                 $time, res_if.next_cells, res_if.frame_end);
      end else begin
        head_row = pending_rows.pop_front();
        if (res_if.next_cells !== head_row.next_cells) begin
          faults++;
          $display("%0t: next_cells expected %h actual %h",
                   $time, head_row.next_cells, res_if.next_cells);
        end
        if (res_if.frame_end !== head_row.frame_end) begin
          faults++;
          $display("%0t: frame_end expected %b actual %b",
                   $time, head_row.frame_end, res_if.frame_end);
        end
      end
    end
  end

  initial begin
    int depth;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = WIDTH_RESET;
    rows_if.valid     = 1'b0;
    rows_if.row_cells = '0;
    rows_if.final_row = 1'b0;
    width_reg         = WIDTH_RESET;
    above_row         = '0;
    held_row          = '0;
    held_count        = 2'd0;
    faults            = 0;
    sent_rows         = 0;
    calm              = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (PLAN[i]) begin
      case (PLAN[i].act)
        ACT_WIDTH: set_width(PLAN[i].data[WIDTH_W-1:0]);
        default:   put_row(PLAN[i].data, PLAN[i].fin, PLAN[i].typed, PLAN[i].want);
      endcase
    end

    while (sent_rows < 1200) begin
      if ($urandom_range(99) < 15) set_width(pick_width());
      calm = (sent_rows >= 500 && sent_rows < 700);
      depth = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
      for (int k = 0; k < depth; k++) begin
        // width change while a grid is half way through
        if (k > 0 && $urandom_range(99) < 4) set_width(pick_width());
        put_row(make_row(), k == depth - 1, 1'b0, '0);
      end
    end
    calm = 1'b0;
    rows_if.valid <= 1'b0;

    while (pending_rows.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (faults == 0) begin
      $display("cave_automaton_row_pass_top verification clean");
    end else begin
      $display("cave_automaton_row_pass_top verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("cave_automaton_row_pass_top verification failed");
    $finish;
  end

endmodule
